FILE: hdl/cle_pkg.sv
package cle_pkg;

    // console control bytes and printable range bounds
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        KIND_ECHO    = 2'd0,
        KIND_NEWLINE = 2'd1,
        KIND_ERASE   = 2'd2,
        KIND_CHAR    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PUSH
    } state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

endpackage

FILE: hdl/console_line_editor_top.sv
// Console line editor with echo.
//
// Slave stream: one received console byte per transaction on s_tdata.
// Master stream: echo and line results; m_tuser carries the kind (echo byte,
// newline, erase, line character), m_tdata the byte, m_tlast marks the final
// result of one input byte.
//
// A printable byte with room in the line, or a backspace/DEL with a non-empty
// line, gives one result in the cycle after acceptance; one such byte can be
// taken every cycle while the receiver keeps up. CR or LF (unless right after
// an echoed one) gives the newline echo in the cycle after acceptance, then
// each stored character by a line-store read and an output push, with s_tready
// low until the line is drained. The store is a one-port-read, one-port-write
// RAM with registered reads; the line holds up to LINE_MAX-1 characters.
//
// Reset clears the line length and the line-ending flag; the store itself is
// not cleared. A single output register parts the two sides: when the
// receiver stalls with a result pending, s_tready drops and drain pauses.
module console_line_editor_top #(
    parameter int LINE_MAX = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // data_byte
    output logic [1:0] m_tuser,   // kind
    output logic       m_tlast
);

    localparam int AW = (LINE_MAX > 2) ? $clog2(LINE_MAX) : 1;

    logic             can_push;
    logic             push;
    cle_pkg::result_t push_res;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data;

    cle_ctrl #(
        .LINE_MAX (LINE_MAX),
        .AW       (AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .rx_byte  (s_tdata),
        .can_push (can_push),
        .push     (push),
        .push_res (push_res),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    cle_line_ram #(
        .DEPTH (LINE_MAX),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cle_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_res (push_res),
        .can_push (can_push),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hdl/cle_line_ram.sv
module cle_line_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/cle_out_reg.sv
module cle_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cle_pkg::result_t  push_res,
    output logic              can_push,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // data_byte
    output logic [1:0]        m_tuser,   // kind
    output logic              m_tlast
);

    logic             valid_reg;
    logic             valid_next;
    cle_pkg::result_t res_reg;

    assign can_push = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && can_push)
        begin
            res_reg <= push_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.data;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

endmodule

FILE: hdl/cle_ctrl.sv
module cle_ctrl #(
    parameter int LINE_MAX = 64,
    parameter int AW       = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        rx_byte,
    input  logic              can_push,
    output logic              push,
    output cle_pkg::result_t  push_res,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [7:0]        wr_data,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  logic [7:0]        rd_data
);

    localparam logic [AW-1:0] CAP = AW'(LINE_MAX - 1);

    cle_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   len_reg, len_next;
    logic            after_nl_reg, after_nl_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   end_reg, end_next;

    logic accept;
    logic is_eol;
    logic is_erase;
    logic is_print;

    assign accept   = (state_reg == cle_pkg::ST_IDLE) && s_tvalid && can_push;
    assign is_eol   = rx_byte inside {cle_pkg::CH_CR, cle_pkg::CH_LF};
    assign is_erase = rx_byte inside {cle_pkg::CH_BS, cle_pkg::CH_DEL};
    assign is_print = rx_byte inside {[cle_pkg::CH_SP:cle_pkg::CH_TILDE]};

    // next-state logic for the state registers
    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        after_nl_next = after_nl_reg;
        idx_next      = idx_reg;
        end_next      = end_reg;
        case (state_reg)
            cle_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_eol)
                    begin
                        after_nl_next = !after_nl_reg;
                        if (!after_nl_reg)
                        begin
                            len_next = '0;
                            idx_next = '0;
                            end_next = len_reg - 1'b1;
                            if (len_reg != '0)
                            begin
                                state_next = cle_pkg::ST_READ;
                            end
                        end
                    end
                    else
                    begin
                        after_nl_next = 1'b0;
                        if (is_erase && len_reg != '0)
                        begin
                            len_next = len_reg - 1'b1;
                        end
                        else if (is_print && len_reg < CAP)
                        begin
                            len_next = len_reg + 1'b1;
                        end
                    end
                end
            end
            cle_pkg::ST_READ:
            begin
                state_next = cle_pkg::ST_PUSH;
            end
            cle_pkg::ST_PUSH:
            begin
                if (can_push)
                begin
                    if (idx_reg == end_reg)
                    begin
                        state_next = cle_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = cle_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = cle_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = 1'b0;
        push     = 1'b0;
        push_res = '{kind: cle_pkg::KIND_ECHO, data: 8'h00, last: 1'b0};
        wr_en    = 1'b0;
        wr_addr  = len_reg;
        wr_data  = rx_byte;
        rd_en    = 1'b0;
        rd_addr  = idx_reg;
        case (state_reg)
            cle_pkg::ST_IDLE:
            begin
                s_tready = can_push;
                if (accept)
                begin
                    if (is_eol)
                    begin
                        if (!after_nl_reg)
                        begin
                            push     = 1'b1;
                            push_res = '{kind: cle_pkg::KIND_NEWLINE, data: 8'h00,
                                         last: (len_reg == '0)};
                        end
                    end
                    else if (is_erase)
                    begin
                        if (len_reg != '0)
                        begin
                            push     = 1'b1;
                            push_res = '{kind: cle_pkg::KIND_ERASE, data: 8'h00,
                                         last: 1'b1};
                        end
                    end
                    else if (is_print && len_reg < CAP)
                    begin
                        wr_en    = 1'b1;
                        push     = 1'b1;
                        push_res = '{kind: cle_pkg::KIND_ECHO, data: rx_byte,
                                     last: 1'b1};
                    end
                end
            end
            cle_pkg::ST_READ:
            begin
                rd_en = 1'b1;
            end
            cle_pkg::ST_PUSH:
            begin
                // read data holds until the next read, so waiting here is safe
                if (can_push)
                begin
                    push     = 1'b1;
                    push_res = '{kind: cle_pkg::KIND_CHAR, data: rd_data,
                                 last: (idx_reg == end_reg)};
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cle_pkg::ST_IDLE;
            len_reg      <= '0;
            after_nl_reg <= 1'b0;
            idx_reg      <= '0;
            end_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            after_nl_reg <= after_nl_next;
            idx_reg      <= idx_next;
            end_reg      <= end_next;
        end
    end

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("line store written and read in one cycle");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> can_push)
        else $error("result pushed into a full output register");

    a_drain_len_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cle_pkg::ST_IDLE) |-> (len_reg == '0))
        else $error("line length not cleared during drain");

    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cle_pkg::ST_IDLE) |-> (idx_reg <= end_reg && end_reg < CAP))
        else $error("drain index beyond stored line");

    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CAP)
        else $error("line length above capacity");

endmodule
